// File: rtl/core/sssr_pkg.sv
// Shared types, constants and display tables for the seven-segment score serializer.
// No dependencies; imported by every module of the block.
package sssr_pkg;

   localparam int NumDigits    = 4;
   localparam int DigitBits    = 4;
   localparam int FrameBits    = 16;
   localparam int ScoreBits    = 16;
   localparam int BitsPerScore = NumDigits * FrameBits;

   typedef logic [ScoreBits-1:0] score_type;
   typedef logic [DigitBits-1:0] bcd_digit_type;
   // Element [3] is thousands, element [0] is ones.
   typedef bcd_digit_type [NumDigits-1:0] digit_set_type;
   typedef logic [1:0] position_type;
   typedef logic [$clog2(BitsPerScore)-1:0] bit_count_type;

   // Queue status between the front and the back.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Active-low segment pattern for one decimal digit.
   function automatic logic [7:0] seg_pattern(input bcd_digit_type digit);
      logic [7:0] pattern;
      case (digit)
         4'd0: pattern = 8'hC0;
         4'd1: pattern = 8'hF9;
         4'd2: pattern = 8'hA4;
         4'd3: pattern = 8'hB0;
         4'd4: pattern = 8'h99;
         4'd5: pattern = 8'h92;
         4'd6: pattern = 8'h82;
         4'd7: pattern = 8'hF8;
         4'd8: pattern = 8'h80;
         4'd9: pattern = 8'h90;
         default: pattern = 8'hFF;
      endcase
      return pattern;
   endfunction

   // Digit-select byte for a position, thousands first.
   function automatic logic [7:0] digit_select(input position_type pos);
      logic [7:0] sel;
      case (pos)
         2'd0: sel = 8'hF1;
         2'd1: sel = 8'hF2;
         2'd2: sel = 8'hF4;
         2'd3: sel = 8'hF8;
         default: sel = 8'hF1;
      endcase
      return sel;
   endfunction

endpackage

// File: rtl/core/sssr_front.sv
// Front end: accepts a score word and converts it to four BCD digits by shift-add-3.
// Depends on sssr_pkg.
module sssr_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   output logic                   full,
   input  sssr_pkg::score_type    score_value,
   input  sssr_pkg::queue_status_type q_status,
   output logic                   q_push,
   output sssr_pkg::digit_set_type q_digits
);
   import sssr_pkg::*;

   localparam logic [1:0] StIdle = 2'd0;
   localparam logic [1:0] StConv = 2'd1;
   localparam logic [1:0] StHold = 2'd2;

   logic [1:0]    state_ff, state_in;
   score_type     shift_ff, shift_in;
   digit_set_type bcd_ff, bcd_in;
   logic [$clog2(ScoreBits)-1:0] step_ff, step_in;
   digit_set_type bcd_adj;
   logic [NumDigits*DigitBits-1:0] bcd_flat;
   logic          accept;

   // Hold off while converting, or while the finished digits wait on a full queue.
   assign full     = (state_ff == StConv) || ((state_ff == StHold) && q_status.full);
   assign accept   = push && !full;
   assign q_push   = (state_ff == StHold);
   assign q_digits = bcd_ff;
   assign bcd_flat = bcd_adj;

   always_comb begin
      for (int i = 0; i < NumDigits; i++) begin
         bcd_adj[i] = (bcd_ff[i] >= 4'd5) ? bcd_ff[i] + 4'd3 : bcd_ff[i];
      end
   end

   always_comb begin
      state_in = state_ff;
      shift_in = shift_ff;
      bcd_in   = bcd_ff;
      step_in  = step_ff;
      case (state_ff)
         StIdle: begin
            if (accept) begin
               state_in = StConv;
            end
         end
         StConv: begin
            // Carry out of the thousands digit is dropped: display is modulo 10000.
            bcd_in   = {bcd_flat[NumDigits*DigitBits-2:0], shift_ff[ScoreBits-1]};
            shift_in = {shift_ff[ScoreBits-2:0], 1'b0};
            step_in  = step_ff + 1'b1;
            if (step_ff == '1) begin
               state_in = StHold;
            end
         end
         StHold: begin
            if (!q_status.full) begin
               state_in = accept ? StConv : StIdle;
            end
         end
         default: state_in = StIdle;
      endcase
      if (accept) begin
         shift_in = score_value;
         bcd_in   = '0;
         step_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
      end else begin
         state_ff <= state_in;
      end
      shift_ff <= shift_in;
      bcd_ff   <= bcd_in;
      step_ff  <= step_in;
   end

endmodule

// File: rtl/core/sssr_queue.sv
// Two-entry queue of converted digit sets between front and back.
// Depends on sssr_pkg.
module sssr_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       wr_en,
   input  sssr_pkg::digit_set_type    wr_data,
   input  logic                       rd_en,
   output sssr_pkg::digit_set_type    rd_data,
   output sssr_pkg::queue_status_type status
);
   import sssr_pkg::*;

   digit_set_type entry_ff [2];
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    count_ff, count_in;
   logic          do_wr, do_rd;

   assign status.full  = (count_ff == 2'd2);
   assign status.empty = (count_ff == 2'd0);
   assign do_wr   = wr_en && !status.full;
   assign do_rd   = rd_en && !status.empty;
   assign rd_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_wr ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_rd ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_wr} - {1'b0, do_rd};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_wr) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// File: rtl/core/sssr_back.sv
// Back end: walks the four 16-bit frames of one digit set, one bit per cycle while pop keeps up,
// into a registered result stage. Depends on sssr_pkg.
module sssr_back (
   input  logic                       clock,
   input  logic                       reset,
   input  sssr_pkg::queue_status_type q_status,
   input  sssr_pkg::digit_set_type    q_digits,
   output logic                       q_pop,
   output logic                       empty,
   input  logic                       pop,
   output logic                       serial_bit,
   output sssr_pkg::position_type     digit_position,
   output logic                       latch_after,
   output logic                       last_of_run
);
   import sssr_pkg::*;

   logic          active_ff, active_in;
   bit_count_type count_ff, count_in;
   digit_set_type digits_ff, digits_in;
   logic          out_valid_ff, out_valid_in;
   logic          bit_ff, bit_in;
   position_type  pos_ff, pos_in;
   logic          latch_ff, latch_in;
   logic          last_ff, last_in;

   position_type   cur_pos;
   logic [3:0]     cur_bit;
   bcd_digit_type  cur_digit;
   logic [FrameBits-1:0] frame;
   logic           advance, at_last, take;

   assign cur_pos   = count_ff[5:4];
   assign cur_bit   = count_ff[3:0];
   assign cur_digit = digits_ff[~cur_pos];
   assign frame     = {seg_pattern(cur_digit), digit_select(cur_pos)};

   assign advance = active_ff && (!out_valid_ff || pop);
   assign at_last = (count_ff == '1);
   assign take    = !q_status.empty && (!active_ff || (advance && at_last));
   assign q_pop   = take;

   always_comb begin
      active_in    = active_ff;
      count_in     = count_ff;
      digits_in    = digits_ff;
      out_valid_in = out_valid_ff;
      bit_in       = bit_ff;
      pos_in       = pos_ff;
      latch_in     = latch_ff;
      last_in      = last_ff;
      if (advance) begin
         // Frame goes out MSB first.
         out_valid_in = 1'b1;
         bit_in       = frame[~cur_bit];
         pos_in       = cur_pos;
         latch_in     = (cur_bit == 4'hF);
         last_in      = at_last;
         count_in     = count_ff + 1'b1;
         if (at_last) begin
            active_in = 1'b0;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
      if (take) begin
         active_in = 1'b1;
         count_in  = '0;
         digits_in = q_digits;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         active_ff    <= active_in;
         out_valid_ff <= out_valid_in;
         count_ff     <= count_in;
      end
      digits_ff <= digits_in;
      bit_ff    <= bit_in;
      pos_ff    <= pos_in;
      latch_ff  <= latch_in;
      last_ff   <= last_in;
   end

   assign empty          = !out_valid_ff;
   assign serial_bit     = bit_ff;
   assign digit_position = pos_ff;
   assign latch_after    = latch_ff;
   assign last_of_run    = last_ff;

endmodule

// File: rtl/core/seven_segment_score_serializer.sv
// Seven-segment score serializer, top level: front converter, digit queue, bit serializer.
// Depends on sssr_pkg, sssr_front, sssr_queue and sssr_back.
//
// Each 16-bit score pushed in is shown as four decimal digits (modulo 10000), thousands
// first, and comes out as 64 result words of one serial bit each: per digit a 16-bit
// frame, MSB first, of the active-low segment byte followed by the digit-select byte
// (F1, F2, F4, F8 for thousands..ones). latch_after marks the last bit of each frame,
// last_of_run the 64th bit of the score. One result word leaves per cycle while pop
// keeps up. The front converts a score by one shift-add-3 step per binary bit, and a
// two-entry queue lets it take the next scores while earlier ones are still shifting
// out; full rises only while a conversion runs or the queue is full. Reset is
// synchronous and active high; no configuration is needed.
module seven_segment_score_serializer (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   output logic                   full,
   input  logic [15:0]            req_score_value,
   output logic                   empty,
   input  logic                   pop,
   output logic                   rsp_serial_bit,
   output logic [1:0]             rsp_digit_position,
   output logic                   rsp_latch_after,
   output logic                   rsp_last_of_run
);
   import sssr_pkg::*;

   queue_status_type q_status;
   digit_set_type    wr_digits;
   digit_set_type    rd_digits;
   logic             q_push;
   logic             q_pop;

   // Front: take a score word, convert to BCD, hand the digits to the queue.
   sssr_front u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .score_value (req_score_value),
      .q_status    (q_status),
      .q_push      (q_push),
      .q_digits    (wr_digits)
   );

   // Decouple conversion from serialization.
   sssr_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (q_push),
      .wr_data (wr_digits),
      .rd_en   (q_pop),
      .rd_data (rd_digits),
      .status  (q_status)
   );

   // Back: shift out four frames per digit set through a registered result stage.
   sssr_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_status       (q_status),
      .q_digits       (rd_digits),
      .q_pop          (q_pop),
      .empty          (empty),
      .pop            (pop),
      .serial_bit     (rsp_serial_bit),
      .digit_position (rsp_digit_position),
      .latch_after    (rsp_latch_after),
      .last_of_run    (rsp_last_of_run)
   );

endmodule

// File: test/tb_seven_segment_score_serializer.sv
`timescale 1ns / 1ps
// Testbench for seven_segment_score_serializer: scores in, 64 serial bit words per score out.
// Depends on sssr_pkg and the RTL of the block; carries its own predictor of the bit stream.
module tb_seven_segment_score_serializer;
   import sssr_pkg::*;

   localparam int CycleLimit  = 600000;
   localparam int DrainCycles = 150;
   localparam int MaxPrinted  = 40;

   // Active-low segment bytes, digit 0 in the low byte up to digit 9 in the high byte.
   localparam logic [79:0] SegCodes = {8'h90, 8'h80, 8'hF8, 8'h82, 8'h92,
                                       8'h99, 8'hB0, 8'hA4, 8'hF9, 8'hC0};
   // Digit-select bytes, thousands in the low byte.
   localparam logic [31:0] SelectCodes = {8'hF8, 8'hF4, 8'hF2, 8'hF1};

   // One result word as it should leave the block.
   typedef struct {
      logic         serial_bit;
      position_type digit_position;
      logic         latch_after;
      logic         last_of_run;
   } serial_word_type;

   // Receiver stall patterns.
   typedef enum logic [1:0] {RxSteady, RxCoin, RxSparse, RxPeriodic} rx_mode_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         push = 1'b0;
   logic         full;
   score_type    req_score_value = '0;
   logic         empty;
   logic         pop = 1'b0;
   logic         rsp_serial_bit;
   position_type rsp_digit_position;
   logic         rsp_latch_after;
   logic         rsp_last_of_run;

   serial_word_type pending_bits[$];
   int              fail_count = 0;
   int              cycle_count = 0;

   // Long receiver hold: the test side sets the length and toggles the trigger,
   // the receiver process counts the hold down on its own.
   int   hold_length = 0;
   logic hold_trigger = 1'b0;

   seven_segment_score_serializer uut (
      .clock              (clock),
      .reset              (reset),
      .push               (push),
      .full               (full),
      .req_score_value    (req_score_value),
      .empty              (empty),
      .pop                (pop),
      .rsp_serial_bit     (rsp_serial_bit),
      .rsp_digit_position (rsp_digit_position),
      .rsp_latch_after    (rsp_latch_after),
      .rsp_last_of_run    (rsp_last_of_run)
   );

   always #10 clock = ~clock;

   // Expand one accepted score into its 64 bit words: four frames, thousands first,
   // each frame the segment byte then the select byte, MSB first.
   function automatic void queue_score_bits(input score_type score);
      int unsigned     digits [NumDigits];
      int unsigned     rest;
      logic [15:0]     frame;
      serial_word_type word;
      rest = score;
      // Peel off the ones first; anything above the thousands simply drops out.
      for (int pos = NumDigits - 1; pos >= 0; pos--) begin
         digits[pos] = rest % 10;
         rest = rest / 10;
      end
      for (int pos = 0; pos < NumDigits; pos++) begin
         frame = {SegCodes[digits[pos]*8 +: 8], SelectCodes[pos*8 +: 8]};
         for (int b = FrameBits - 1; b >= 0; b--) begin
            word.serial_bit     = frame[b];
            word.digit_position = position_type'(pos);
            word.latch_after    = (b == 0);
            word.last_of_run    = (b == 0) && (pos == NumDigits - 1);
            pending_bits.push_back(word);
         end
      end
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      fail_count++;
      if (fail_count <= MaxPrinted)
         $display("mismatch at cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
   endtask

   // Offer one score at the falling edge and hold it until the block takes it.
   // Leave push high afterwards so that back-to-back scores need no toggle.
   task automatic send_score(input score_type score);
      @(negedge clock);
      push <= 1'b1;
      req_score_value <= score;
      forever begin
         @(posedge clock);
         if (!full) break;
      end
      queue_score_bits(score);
   endtask

   // Drop push for a number of cycles.
   task automatic idle_sender(input int cycles);
      @(negedge clock);
      push <= 1'b0;
      req_score_value <= score_type'($urandom);
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic hold_receiver(input int cycles);
      hold_length = cycles;
      hold_trigger = ~hold_trigger;
   endtask

   // Every digit value at every position, the wrap above 9999 and both
   // extremes of the score field.
   task automatic test_directed_scores();
      score_type scores [20];
      scores = '{16'd0, 16'd1111, 16'd2222, 16'd3333, 16'd4444, 16'd5555,
                 16'd6666, 16'd7777, 16'd8888, 16'd9999, 16'd10000, 16'd65535,
                 16'd1234, 16'd5678, 16'd9090, 16'd19999, 16'd32768, 16'd43210,
                 16'd1, 16'd10};
      foreach (scores[i]) send_score(scores[i]);
      idle_sender(3);
   endtask

   // Bursts of random length with random gaps; most scores span the full
   // field, the rest stay in the four-digit range or hug the edges.
   task automatic test_random_bursts(input int count);
      int        sent;
      int        burst;
      int        pick;
      score_type score;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 8);
         for (int i = 0; i < burst && sent < count; i++) begin
            pick = $urandom_range(0, 9);
            if (pick <= 5)
               score = score_type'($urandom);
            else if (pick <= 7)
               score = score_type'($urandom_range(0, 9999));
            else if (pick == 8)
               score = score_type'($urandom_range(0, 1) ? $urandom_range(9990, 10010)
                                                        : $urandom_range(65500, 65535));
            else
               score = score_type'($urandom_range(0, 99));
            send_score(score);
            sent++;
         end
         // Leave some bursts glued together, space the others by up to two scores.
         if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 130));
      end
   endtask

   // Hold the receiver off for a long stretch and keep offering scores, so
   // the queue fills and full stalls the sender.
   task automatic test_receiver_backpressure();
      hold_receiver(900);
      for (int i = 0; i < 10; i++) send_score(score_type'($urandom));
      idle_sender(5);
   endtask

   // Receiver: pop on a pattern (steady, coin toss, sparse or periodic) that is redrawn at
   // random when its stretch of random length runs out; a pending hold overrides it.
   always @(negedge clock) begin : receiver
      static rx_mode_type rx_mode = RxSteady;
      static int          mode_left = 100;
      static int          hold_left = 0;
      static int          phase = 0;
      static logic        hold_seen = 1'b0;
      logic               want;
      if (hold_trigger != hold_seen) begin
         hold_seen = hold_trigger;
         hold_left = hold_length;
      end
      if (mode_left == 0) begin
         rx_mode = rx_mode_type'($urandom_range(0, 3));
         mode_left = $urandom_range(50, 300);
      end else begin
         mode_left--;
      end
      phase++;
      case (rx_mode)
         RxSteady:   want = 1'b1;
         RxCoin:     want = $urandom_range(0, 1);
         RxSparse:   want = ($urandom_range(0, 3) == 0);
         default:    want = (phase % 5 != 0);
      endcase
      if (hold_left > 0) begin
         hold_left--;
         want = 1'b0;
      end
      pop <= reset ? 1'b0 : want;
   end

   // Check every word taken at a rising edge against the oldest expectation.
   always @(posedge clock) begin : check_words
      serial_word_type due;
      if (!reset && pop && !empty) begin
         if (pending_bits.size() == 0) begin
            report_mismatch("word with nothing expected, serial_bit", rsp_serial_bit, 0);
         end else begin
            due = pending_bits.pop_front();
            if (rsp_serial_bit !== due.serial_bit)
               report_mismatch("serial_bit", rsp_serial_bit, due.serial_bit);
            if (rsp_digit_position !== due.digit_position)
               report_mismatch("digit_position", rsp_digit_position, due.digit_position);
            if (rsp_latch_after !== due.latch_after)
               report_mismatch("latch_after", rsp_latch_after, due.latch_after);
            if (rsp_last_of_run !== due.last_of_run)
               report_mismatch("last_of_run", rsp_last_of_run, due.last_of_run);
         end
      end
   end

   // Watchdog: end a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("[seven_segment_score_serializer] ERROR");
         $finish;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      idle_sender(3);

      test_directed_scores();
      test_random_bursts(175);
      test_receiver_backpressure();
      test_random_bursts(175);

      // Drain: wait for the last word, then give stray words time to show.
      idle_sender(1);
      while (pending_bits.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      if (fail_count == 0)
         $display("[seven_segment_score_serializer] OK");
      else
         $display("[seven_segment_score_serializer] ERROR");
      $finish;
   end

endmodule
